/* design/joystick_to_thruster_mixer_macros.svh */
// Assertion helpers for the thruster mixer.
`ifndef JOYSTICK_TO_THRUSTER_MIXER_MACROS_SVH
`define JOYSTICK_TO_THRUSTER_MIXER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle (or sequence) implication checked at every rising clock edge.
`define JTM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> cons) \
        else $error("mixer check failed");

// Next-cycle implication.
`define JTM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> cons) \
        else $error("mixer check failed");

`else

`define JTM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define JTM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

/* design/jtm_pkg.sv */
`timescale 1ns / 1ps
package jtm_pkg;

    // Configuration register fields
    localparam int DZ_W = 15;
    localparam logic [DZ_W-1:0] DZ_RESET = 15'd1638;

    // Output field width and flag byte layout
    localparam int THR_W = 8;
    localparam logic [THR_W-1:0] FLAGS_BASE = 8'h81;
    localparam int FLAG_LEFT_REV = 1;
    localparam int FLAG_RIGHT_REV = 2;
    localparam int FLAG_CENTER_REV = 3;

    // 1/cos(pi/8) in Q1.30
    localparam int SEC_W = 31;
    localparam logic [SEC_W-1:0] SEC_PI8 = 31'd1162209775;
    localparam int SEC_SHIFT = 30;

    // Register index (byte address bit 2)
    typedef enum logic {
        REG_STICK_DZ  = 1'b0,
        REG_CENTER_DZ = 1'b1
    } reg_idx_t;

    // Control travelling alongside the square-root payload
    typedef struct packed {
        logic valid;
    } sqrt_ctl_t;

endpackage

/* design/joystick_to_thruster_mixer.sv */
`timescale 1ns / 1ps
// Stick-to-thruster mixer.
// Command channel: drive axis_x, axis_y, axis_center with start high; the
// sample is taken at the rising edge where start is high and busy is low.
// busy stays low, so a new sample may be issued in every cycle.
// Result channel: left/right/center throttle and command_flags appear together
// for exactly one cycle with done high. There is no backpressure: the receiver
// must take each result in the cycle it is shown.
// Path from the accepting edge to done: stage registers A, B, C, then the
// square-root pipeline, which resolves two root bits per stage and sets most
// of the latency, then D, E and F. Throughput is one sample per cycle.
// Configuration: APB port, stick_dead_zone at 0x0, center_dead_zone at 0x4,
// both reset to 1638. Write them only while no sample is in flight.
// Reset: rst_n clears the pipeline valid bits and loads the dead-zone
// defaults; samples in flight are dropped.
module joystick_to_thruster_mixer #(
    parameter int AXIS_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [AXIS_WIDTH-1:0] axis_x,
    input  logic signed [AXIS_WIDTH-1:0] axis_y,
    input  logic signed [AXIS_WIDTH-1:0] axis_center,
    output logic                         done,
    output logic [jtm_pkg::THR_W-1:0]    left_throttle,
    output logic [jtm_pkg::THR_W-1:0]    right_throttle,
    output logic [jtm_pkg::THR_W-1:0]    center_throttle,
    output logic [jtm_pkg::THR_W-1:0]    command_flags,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import jtm_pkg::*;

    localparam int AW   = AXIS_WIDTH;
    localparam int F    = AW - 1;
    localparam int NS   = (F + 1) / 2;
    localparam int LAT  = 6 + NS;
    localparam int SQW  = 2 * AW;
    localparam int SUMW = 2 * AW + 1;
    localparam int CMPW = (SUMW > 2 * DZ_W) ? SUMW : 2 * DZ_W;
    localparam int CZW  = (AW > DZ_W) ? AW : DZ_W;
    localparam int XPW  = AW + SEC_W;
    localparam int OPW  = AW + 3;
    localparam int PW   = F + 2 + OPW;
    localparam int SIDE_W = 2 * OPW + 1 + THR_W + 1;

    // ---------------- configuration ----------------
    logic [DZ_W-1:0] stick_dz_reg;
    logic [DZ_W-1:0] center_dz_reg;
    logic            cfg_wr;
    reg_idx_t        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_dz_reg  <= DZ_RESET;
            center_dz_reg <= DZ_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_STICK_DZ:  stick_dz_reg  <= pwdata[DZ_W-1:0];
                REG_CENTER_DZ: center_dz_reg <= pwdata[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_STICK_DZ:  prdata = 32'(stick_dz_reg);
            REG_CENTER_DZ: prdata = 32'(center_dz_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- stage A: capture ----------------
    logic                       accept;
    logic                       a_valid_reg;
    logic signed [AW-1:0]       a_x_reg;
    logic signed [AW:0]         a_up_reg;
    logic signed [AW-1:0]       a_c_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg  <= axis_x;
            a_up_reg <= -((AW+1)'(axis_y));
            a_c_reg  <= axis_center;
        end
    end

    // ---------------- stage B: squares, secant scale, centre motor ----------------
    logic [AW-1:0]    ax_next;
    logic [AW-1:0]    au_next;
    logic [AW-1:0]    ac_next;
    logic [AW:0]      axu_next;
    logic [XPW-1:0]   xs_prod;
    logic [AW+7:0]    c255;
    logic [AW+7:0]    cshift;
    logic             cdead;
    logic [THR_W-1:0] ct_next;

    logic             b_valid_reg;
    logic [SQW-1:0]   b_sqx_reg;
    logic [SQW-1:0]   b_squ_reg;
    logic [SQW+1:0]   b_sqs_reg;
    logic [AW:0]      b_xs_reg;
    logic [2*DZ_W-1:0] b_dzsq_reg;
    logic signed [AW-1:0] b_x_reg;
    logic             b_xneg_reg;
    logic             b_xzero_reg;
    logic             b_upneg_reg;
    logic             b_upzero_reg;
    logic [THR_W-1:0] b_ct_reg;
    logic             b_crev_reg;

    always_comb
    begin
        ax_next  = a_x_reg[AW-1] ? AW'(-a_x_reg) : AW'(a_x_reg);
        au_next  = a_up_reg[AW] ? AW'(-a_up_reg) : AW'(a_up_reg);
        ac_next  = a_c_reg[AW-1] ? AW'(-a_c_reg) : AW'(a_c_reg);
        axu_next = (AW+1)'(ax_next) + (AW+1)'(au_next);
        xs_prod  = XPW'(ax_next) * XPW'(SEC_PI8);
        cdead    = CZW'(ac_next) < CZW'(center_dz_reg);
        c255     = {ac_next, 8'b0} - (AW+8)'(ac_next);
        cshift   = c255 >> F;
        if (cdead)
        begin
            ct_next = '0;
        end
        else if (|cshift[AW+7:THR_W])
        begin
            ct_next = '1;
        end
        else
        begin
            ct_next = cshift[THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_sqx_reg    <= SQW'(ax_next) * SQW'(ax_next);
        b_squ_reg    <= SQW'(au_next) * SQW'(au_next);
        b_sqs_reg    <= (SQW+2)'(axu_next) * (SQW+2)'(axu_next);
        b_xs_reg     <= xs_prod[SEC_SHIFT +: AW+1];
        b_dzsq_reg   <= (2*DZ_W)'(stick_dz_reg) * (2*DZ_W)'(stick_dz_reg);
        b_x_reg      <= a_x_reg;
        b_xneg_reg   <= a_x_reg[AW-1];
        b_xzero_reg  <= (a_x_reg == '0);
        b_upneg_reg  <= a_up_reg[AW];
        b_upzero_reg <= (a_up_reg == '0);
        b_ct_reg     <= ct_next;
        b_crev_reg   <= a_c_reg[AW-1] && !cdead;
    end

    // ---------------- stage C: stick dead zone, sector, motor operands ----------------
    logic [SUMW-1:0]        sumsq;
    logic                   stick_dead;
    logic                   backward;
    logic signed [OPW-1:0]  x_op;
    logic signed [OPW-1:0]  xs_op;
    logic signed [OPW-1:0]  one_op;
    logic signed [OPW-1:0]  lop_next;
    logic signed [OPW-1:0]  rop_next;

    logic                   c_valid_reg;
    logic [2*F-1:0]         c_n_reg;
    logic [SIDE_W-1:0]      c_side_reg;

    always_comb
    begin
        sumsq      = SUMW'(b_sqx_reg) + SUMW'(b_squ_reg);
        stick_dead = CMPW'(sumsq) < CMPW'(b_dzsq_reg);
        backward   = (SQW+2)'(b_sqs_reg) > {b_sqx_reg, 1'b0};
        x_op       = OPW'(b_x_reg);
        xs_op      = OPW'(b_xs_reg);
        one_op     = OPW'(1) << F;
        lop_next   = '0;
        rop_next   = '0;
        if (!stick_dead)
        begin
            if (!b_upneg_reg)
            begin
                if ((!b_xneg_reg && !b_xzero_reg) || (b_xzero_reg && b_upzero_reg))
                begin
                    lop_next = x_op;
                    rop_next = one_op - x_op;
                end
                else
                begin
                    lop_next = one_op + x_op;
                    rop_next = -x_op;
                end
            end
            else if (backward)
            begin
                // backward-left is the mirror image of backward-right
                if (!b_xneg_reg)
                begin
                    lop_next = -xs_op;
                    rop_next = xs_op - one_op;
                end
                else
                begin
                    lop_next = xs_op - one_op;
                    rop_next = -xs_op;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    // Saturate radius at one: feed zero to the root and force the result later
    always_ff @(posedge clk)
    begin
        c_n_reg    <= (|sumsq[SUMW-1:2*F]) ? '0 : sumsq[2*F-1:0];
        c_side_reg <= {lop_next, rop_next, |sumsq[SUMW-1:2*F], b_ct_reg, b_crev_reg};
    end

    // ---------------- radius square root ----------------
    sqrt_ctl_t         sq_ctl_in;
    sqrt_ctl_t         sq_ctl_out;
    logic [F-1:0]      sq_root;
    logic [SIDE_W-1:0] sq_side;

    assign sq_ctl_in.valid = c_valid_reg;

    jtm_sqrt_pipe #(
        .W      (F),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (sq_ctl_in),
        .n        (c_n_reg),
        .side_in  (c_side_reg),
        .ctl_out  (sq_ctl_out),
        .root     (sq_root),
        .side_out (sq_side)
    );

    // ---------------- stage D: radius times operand ----------------
    logic signed [OPW-1:0] d_lop;
    logic signed [OPW-1:0] d_rop;
    logic                  d_sat;
    logic [THR_W-1:0]      d_ct;
    logic                  d_crev;
    logic [F:0]            radius;

    logic                  d_valid_reg;
    logic signed [PW-1:0]  d_lv_reg;
    logic signed [PW-1:0]  d_rv_reg;
    logic [THR_W-1:0]      d_ct_reg;
    logic                  d_crev_reg;

    assign {d_lop, d_rop, d_sat, d_ct, d_crev} = sq_side;
    assign radius = d_sat ? ((F+1)'(1) << F) : (F+1)'(sq_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= sq_ctl_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_lv_reg   <= PW'(signed'({1'b0, radius})) * PW'(d_lop);
        d_rv_reg   <= PW'(signed'({1'b0, radius})) * PW'(d_rop);
        d_ct_reg   <= d_ct;
        d_crev_reg <= d_crev;
    end

    // ---------------- stage E: sign and magnitude ----------------
    logic             e_valid_reg;
    logic [PW-1:0]    e_lmag_reg;
    logic [PW-1:0]    e_rmag_reg;
    logic             e_lneg_reg;
    logic             e_rneg_reg;
    logic [THR_W-1:0] e_ct_reg;
    logic             e_crev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_lmag_reg <= d_lv_reg[PW-1] ? PW'(-d_lv_reg) : PW'(d_lv_reg);
        e_rmag_reg <= d_rv_reg[PW-1] ? PW'(-d_rv_reg) : PW'(d_rv_reg);
        e_lneg_reg <= d_lv_reg[PW-1];
        e_rneg_reg <= d_rv_reg[PW-1];
        e_ct_reg   <= d_ct_reg;
        e_crev_reg <= d_crev_reg;
    end

    // ---------------- stage F: throttle scaling, output ----------------
    logic [PW+7:0]    l255;
    logic [PW+7:0]    r255;
    logic [PW+7:0]    lsh;
    logic [PW+7:0]    rsh;
    logic [THR_W-1:0] lt_next;
    logic [THR_W-1:0] rt_next;
    logic [THR_W-1:0] flags_next;

    logic             f_valid_reg;
    logic [THR_W-1:0] f_lt_reg;
    logic [THR_W-1:0] f_rt_reg;
    logic [THR_W-1:0] f_ct_reg;
    logic [THR_W-1:0] f_flags_reg;

    always_comb
    begin
        l255    = {e_lmag_reg, 8'b0} - (PW+8)'(e_lmag_reg);
        r255    = {e_rmag_reg, 8'b0} - (PW+8)'(e_rmag_reg);
        lsh     = l255 >> (2 * F);
        rsh     = r255 >> (2 * F);
        lt_next = (|lsh[PW+7:THR_W]) ? '1 : lsh[THR_W-1:0];
        rt_next = (|rsh[PW+7:THR_W]) ? '1 : rsh[THR_W-1:0];
        flags_next = FLAGS_BASE;
        flags_next[FLAG_LEFT_REV]   = e_lneg_reg;
        flags_next[FLAG_RIGHT_REV]  = e_rneg_reg;
        flags_next[FLAG_CENTER_REV] = e_crev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_lt_reg    <= lt_next;
        f_rt_reg    <= rt_next;
        f_ct_reg    <= e_ct_reg;
        f_flags_reg <= flags_next;
    end

    assign done            = f_valid_reg;
    assign left_throttle   = f_lt_reg;
    assign right_throttle  = f_rt_reg;
    assign center_throttle = f_ct_reg;
    assign command_flags   = f_flags_reg;

    // ---------------- checks ----------------
`include "joystick_to_thruster_mixer_macros.svh"

    `JTM_ASSERT_IMP(a_latency, clk, rst_n, accept, ##LAT done)
    `JTM_ASSERT_IMP(a_zero_not_rev, clk, rst_n, e_valid_reg && e_lmag_reg == '0, !e_lneg_reg)
    `JTM_ASSERT_NXT(a_cfg_stick, clk, rst_n, cfg_wr && cfg_idx == REG_STICK_DZ, stick_dz_reg == $past(pwdata[DZ_W-1:0]))

endmodule

/* design/jtm_sqrt_pipe.sv */
`timescale 1ns / 1ps
module jtm_sqrt_pipe #(
    parameter int W = 15,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jtm_pkg::sqrt_ctl_t    ctl_in,
    input  logic [2*W-1:0]        n,
    input  logic [SIDE_W-1:0]     side_in,
    output jtm_pkg::sqrt_ctl_t    ctl_out,
    output logic [W-1:0]          root,
    output logic [SIDE_W-1:0]     side_out
);
    import jtm_pkg::*;

    // Two result bits resolved per stage
    localparam int NS = (W + 1) / 2;

    logic [2*W-1:0]    n_reg    [NS];
    logic [W+1:0]      rem_reg  [NS];
    logic [W-1:0]      root_reg [NS];
    logic [SIDE_W-1:0] side_reg [NS];
    logic              vld_reg  [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [2*W-1:0]    n_src;
        logic [W+1:0]      rem_src;
        logic [W-1:0]      root_src;
        logic [SIDE_W-1:0] side_src;
        logic              vld_src;
        logic [2*W-1:0]    n_v    [3];
        logic [W+1:0]      rem_v  [3];
        logic [W-1:0]      root_v [3];
        logic [W+1:0]      rem_sh [2];
        logic [W+1:0]      trial  [2];

        if (s == 0) begin : g_first
            assign n_src    = n;
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = side_in;
            assign vld_src  = ctl_in.valid;
        end else begin : g_next
            assign n_src    = n_reg[s-1];
            assign rem_src  = rem_reg[s-1];
            assign root_src = root_reg[s-1];
            assign side_src = side_reg[s-1];
            assign vld_src  = vld_reg[s-1];
        end

        always_comb
        begin
            n_v[0]    = n_src;
            rem_v[0]  = rem_src;
            root_v[0] = root_src;
            for (int j = 0; j < 2; j++)
            begin
                rem_sh[j] = {rem_v[j][W-1:0], n_v[j][2*W-1 -: 2]};
                trial[j]  = {root_v[j], 2'b01};
                if (2 * s + j < W)
                begin
                    n_v[j+1] = {n_v[j][2*W-3:0], 2'b00};
                    if (rem_sh[j] >= trial[j])
                    begin
                        rem_v[j+1]  = rem_sh[j] - trial[j];
                        root_v[j+1] = {root_v[j][W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_v[j+1]  = rem_sh[j];
                        root_v[j+1] = {root_v[j][W-2:0], 1'b0};
                    end
                end
                else
                begin
                    n_v[j+1]    = n_v[j];
                    rem_v[j+1]  = rem_v[j];
                    root_v[j+1] = root_v[j];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[s]    <= n_v[2];
            rem_reg[s]  <= rem_v[2];
            root_reg[s] <= root_v[2];
            side_reg[s] <= side_src;
        end
    end

    assign ctl_out.valid = vld_reg[NS-1];
    assign root          = root_reg[NS-1];
    assign side_out      = side_reg[NS-1];

endmodule
